[sv/prr_pkg.sv]
package prr_pkg;

  localparam int unsigned MacW = 48;
  localparam int unsigned IpW  = 32;
  localparam int unsigned HwW  = 16;

  localparam int unsigned InDataW  = 272;
  localparam int unsigned OutDataW = 176;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [HwW-1:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [7:0]     PROTO_TCP       = 8'd6;
  localparam logic [6:0]     ETH_HDR_BYTES   = 7'd14;
  localparam logic [HwW-1:0] MIN_FRAME_BYTES = 16'd34;
  localparam logic [3:0]     IHL_MIN         = 4'd5;

  localparam logic [IpW-1:0]  CLNT_IP_RST      = 32'h0A00_0001;
  localparam logic [MacW-1:0] CLNT_MAC_RST     = 48'hDEAD_AAAA_0001;
  localparam logic [IpW-1:0]  BALANCER_IP_RST  = 32'h0A00_000A;
  localparam logic [MacW-1:0] BALANCER_MAC_RST = 48'hDEAD_AAAA_0010;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLNT_IP      = 3'd0,
    CFG_CLNT_MAC     = 3'd1,
    CFG_BALANCER_IP  = 3'd2,
    CFG_BALANCER_MAC = 3'd3,
    CFG_BACKEND0_IP  = 3'd4,
    CFG_BACKEND0_MAC = 3'd5,
    CFG_BACKEND1_IP  = 3'd6,
    CFG_BACKEND1_MAC = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [IpW-1:0]  clnt_ip;
    logic [MacW-1:0] clnt_mac;
    logic [IpW-1:0]  balancer_ip;
    logic [MacW-1:0] balancer_mac;
    logic [IpW-1:0]  backend0_ip;
    logic [MacW-1:0] backend0_mac;
    logic [IpW-1:0]  backend1_ip;
    logic [MacW-1:0] backend1_mac;
  } cfg_t;

  typedef struct packed {
    logic [HwW-1:0]  frame_length;
    logic [MacW-1:0] dest_mac;
    logic [MacW-1:0] source_mac;
    logic [HwW-1:0]  ether_type;
    logic [HwW-1:0]  version_ihl_tos;
    logic [HwW-1:0]  total_len;
    logic [HwW-1:0]  ident;
    logic [HwW-1:0]  flags_fragment;
    logic [HwW-1:0]  ttl_protocol;
    logic [IpW-1:0]  src_ip;
    logic [IpW-1:0]  dst_ip;
  } hdr_t;

  typedef struct packed {
    logic            verdict;
    logic [MacW-1:0] new_dest_mac;
    logic [MacW-1:0] new_source_mac;
    logic [IpW-1:0]  new_src_ip;
    logic [IpW-1:0]  new_dst_ip;
    logic [HwW-1:0]  new_checksum;
  } res_t;

  typedef struct packed {
    logic to_backend;
    logic advance_rr;
  } rr_ctl_t;

endpackage

[sv/prr_rewrite.sv]
module prr_rewrite (
  input  prr_pkg::hdr_t    hdr_i,
  input  prr_pkg::cfg_t    cfg_i,
  input  logic             next_backend_i,
  output prr_pkg::res_t    res_o,
  output prr_pkg::rr_ctl_t ctl_o
);

  logic [3:0]            ihl;
  logic [6:0]            hdr_end;
  logic                  valid_hdr;
  logic                  from_client;
  logic [prr_pkg::IpW-1:0]  dst_ip;
  logic [prr_pkg::MacW-1:0] dst_mac;
  logic [19:0]           sum;
  logic [16:0]           fold1;
  logic [15:0]           fold2;

  assign ihl     = hdr_i.version_ihl_tos[11:8];
  assign hdr_end = prr_pkg::ETH_HDR_BYTES + {1'b0, ihl, 2'b00};

  // The 34 byte minimum already covers the bare Ethernet header check.
  assign valid_hdr = (hdr_i.frame_length >= prr_pkg::MIN_FRAME_BYTES)
                  && (hdr_i.ether_type == prr_pkg::ETYPE_IPV4)
                  && (hdr_i.ttl_protocol[7:0] == prr_pkg::PROTO_TCP)
                  && (ihl >= prr_pkg::IHL_MIN)
                  && ({9'd0, hdr_end} <= hdr_i.frame_length);

  assign from_client = (hdr_i.src_ip == cfg_i.clnt_ip);

  always_comb begin
    if (!from_client) begin
      dst_ip  = cfg_i.clnt_ip;
      dst_mac = cfg_i.clnt_mac;
    end else if (next_backend_i) begin
      dst_ip  = cfg_i.backend1_ip;
      dst_mac = cfg_i.backend1_mac;
    end else begin
      dst_ip  = cfg_i.backend0_ip;
      dst_mac = cfg_i.backend0_mac;
    end
  end

  // Nine halfwords plus a zero checksum field; two end-around folds always
  // suffice for a 20 bit sum.
  assign sum = 20'(hdr_i.version_ihl_tos) + 20'(hdr_i.total_len) + 20'(hdr_i.ident)
             + 20'(hdr_i.flags_fragment) + 20'(hdr_i.ttl_protocol)
             + 20'(cfg_i.balancer_ip[31:16]) + 20'(cfg_i.balancer_ip[15:0])
             + 20'(dst_ip[31:16]) + 20'(dst_ip[15:0]);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    if (valid_hdr) begin
      res_o.verdict        = 1'b1;
      res_o.new_dest_mac   = dst_mac;
      res_o.new_source_mac = cfg_i.balancer_mac;
      res_o.new_src_ip     = cfg_i.balancer_ip;
      res_o.new_dst_ip     = dst_ip;
      res_o.new_checksum   = ~fold2;
    end else begin
      res_o.verdict        = 1'b0;
      res_o.new_dest_mac   = hdr_i.dest_mac;
      res_o.new_source_mac = hdr_i.source_mac;
      res_o.new_src_ip     = hdr_i.src_ip;
      res_o.new_dst_ip     = hdr_i.dst_ip;
      res_o.new_checksum   = '0;
    end
  end

  assign ctl_o.to_backend = valid_hdr && from_client;
  assign ctl_o.advance_rr = valid_hdr && from_client;

endmodule

[sv/packet_round_robin_rewriter.sv]
// A header accepted into the input register moves on to the result register,
// which drives the master side; a master stall can hold it in either stage.
// Throughput: one header per cycle; the input register and the result
// register form a two-stage pipeline that stalls only on master back-pressure.
// Reset clears both stage valids, restores every address register to its
// default and points the round robin at backend zero.
module packet_round_robin_rewriter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [prr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [prr_pkg::CfgDataW-1:0]   cfg_data_i,
  // Header input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, low to high: frame_length, dest_mac, source_mac, ether_type,
  // version_ihl_tos, total_len, ident, flags_fragment, ttl_protocol, src_ip, dst_ip
  input  logic [prr_pkg::InDataW-1:0]    s_axis_tdata,
  // Result output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, low to high: new_dest_mac, new_source_mac, new_src_ip, new_dst_ip,
  // new_checksum
  output logic [prr_pkg::OutDataW-1:0]   m_axis_tdata,
  // tuser: verdict
  output logic [0:0]                     m_axis_tuser
);

  prr_pkg::cfg_t    cfg_q;
  prr_pkg::hdr_t    hdr_d, hdr_q;
  prr_pkg::res_t    res_d, res_q;
  prr_pkg::rr_ctl_t ctl;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             next_backend_q;
  logic             out_free;
  logic             in_load;
  logic             out_load;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  assign hdr_d.frame_length    = s_axis_tdata[15:0];
  assign hdr_d.dest_mac        = s_axis_tdata[63:16];
  assign hdr_d.source_mac      = s_axis_tdata[111:64];
  assign hdr_d.ether_type      = s_axis_tdata[127:112];
  assign hdr_d.version_ihl_tos = s_axis_tdata[143:128];
  assign hdr_d.total_len       = s_axis_tdata[159:144];
  assign hdr_d.ident           = s_axis_tdata[175:160];
  assign hdr_d.flags_fragment  = s_axis_tdata[191:176];
  assign hdr_d.ttl_protocol    = s_axis_tdata[207:192];
  assign hdr_d.src_ip          = s_axis_tdata[239:208];
  assign hdr_d.dst_ip          = s_axis_tdata[271:240];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clnt_ip      <= prr_pkg::CLNT_IP_RST;
      cfg_q.clnt_mac     <= prr_pkg::CLNT_MAC_RST;
      cfg_q.balancer_ip  <= prr_pkg::BALANCER_IP_RST;
      cfg_q.balancer_mac <= prr_pkg::BALANCER_MAC_RST;
      cfg_q.backend0_ip  <= '0;
      cfg_q.backend0_mac <= '0;
      cfg_q.backend1_ip  <= '0;
      cfg_q.backend1_mac <= '0;
    end else if (cfg_we_i) begin
      unique case (prr_pkg::cfg_idx_e'(cfg_idx_i))
        prr_pkg::CFG_CLNT_IP:      cfg_q.clnt_ip      <= cfg_data_i[31:0];
        prr_pkg::CFG_CLNT_MAC:     cfg_q.clnt_mac     <= cfg_data_i;
        prr_pkg::CFG_BALANCER_IP:  cfg_q.balancer_ip  <= cfg_data_i[31:0];
        prr_pkg::CFG_BALANCER_MAC: cfg_q.balancer_mac <= cfg_data_i;
        prr_pkg::CFG_BACKEND0_IP:  cfg_q.backend0_ip  <= cfg_data_i[31:0];
        prr_pkg::CFG_BACKEND0_MAC: cfg_q.backend0_mac <= cfg_data_i;
        prr_pkg::CFG_BACKEND1_IP:  cfg_q.backend1_ip  <= cfg_data_i[31:0];
        prr_pkg::CFG_BACKEND1_MAC: cfg_q.backend1_mac <= cfg_data_i;
        default: ;
      endcase
    end
  end

  prr_rewrite u_rewrite (
    .hdr_i          (hdr_q),
    .cfg_i          (cfg_q),
    .next_backend_i (next_backend_q),
    .res_o          (res_d),
    .ctl_o          (ctl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      next_backend_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (out_load) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // The pointer moves only when a client frame leaves the first stage.
      if (out_load && ctl.advance_rr) begin
        next_backend_q <= !next_backend_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      hdr_q <= hdr_d;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid           = out_valid_q;
  assign m_axis_tuser[0]         = res_q.verdict;
  assign m_axis_tdata[47:0]      = res_q.new_dest_mac;
  assign m_axis_tdata[95:48]     = res_q.new_source_mac;
  assign m_axis_tdata[127:96]    = res_q.new_src_ip;
  assign m_axis_tdata[159:128]   = res_q.new_dst_ip;
  assign m_axis_tdata[175:160]   = res_q.new_checksum;

  a_rr_moves_on_client: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(next_backend_q) |-> $past(out_load && ctl.to_backend))
    else $error("round robin pointer moved without a client frame");

  a_pass_zero_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.verdict) |-> (res_q.new_checksum == '0))
    else $error("passed frame carries a non-zero checksum");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed before its transfer");

  a_stage_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("first stage did not hand over to a free result register");

endmodule

[verif/packet_round_robin_rewriter_tb.sv]
module packet_round_robin_rewriter_tb;

  typedef struct {
    prr_pkg::hdr_t h;
    bit            typed;
    prr_pkg::res_t r;
  } stim_row_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [prr_pkg::CfgIdxW-1:0]  cfg_idx_i     = prr_pkg::CFG_CLNT_IP;
  logic [prr_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [prr_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [prr_pkg::OutDataW-1:0] m_axis_tdata;
  logic [0:0]                   m_axis_tuser;

  // Predictor state: the address registers and the round robin pointer.
  prr_pkg::cfg_t lb_cfg;
  bit            rr_next;

  prr_pkg::res_t pending_rewrites[$];
  stim_row_t     dir_rows[$];
  int            mismatches  = 0;
  bit            tx_gaps_on  = 1'b1;
  bit            rx_relaxed  = 1'b1;
  bit            hold_req    = 1'b0;

  packet_round_robin_rewriter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic prr_pkg::res_t rewrite_header(prr_pkg::hdr_t h);
    prr_pkg::res_t r;
    logic [3:0]    ihl;
    int unsigned   need;
    bit            ok;
    logic [31:0]   acc;
    ihl  = h.version_ihl_tos[11:8];
    need = 14 + 4 * ihl;
    ok   = (h.frame_length >= prr_pkg::MIN_FRAME_BYTES) &&
           (h.ether_type == prr_pkg::ETYPE_IPV4) &&
           (h.ttl_protocol[7:0] == prr_pkg::PROTO_TCP) && (ihl >= prr_pkg::IHL_MIN) &&
           (need <= h.frame_length);
    r.verdict        = 1'b0;
    r.new_dest_mac   = h.dest_mac;
    r.new_source_mac = h.source_mac;
    r.new_src_ip     = h.src_ip;
    r.new_dst_ip     = h.dst_ip;
    r.new_checksum   = '0;
    if (ok) begin
      if (h.src_ip == lb_cfg.clnt_ip) begin
        r.new_dst_ip   = rr_next ? lb_cfg.backend1_ip : lb_cfg.backend0_ip;
        r.new_dest_mac = rr_next ? lb_cfg.backend1_mac : lb_cfg.backend0_mac;
        rr_next        = ~rr_next;
      end else begin
        r.new_dst_ip   = lb_cfg.clnt_ip;
        r.new_dest_mac = lb_cfg.clnt_mac;
      end
      r.verdict        = 1'b1;
      r.new_src_ip     = lb_cfg.balancer_ip;
      r.new_source_mac = lb_cfg.balancer_mac;
      // The checksum field itself counts as zero in the sum.
      acc = 32'(h.version_ihl_tos) + 32'(h.total_len) + 32'(h.ident) +
            32'(h.flags_fragment) + 32'(h.ttl_protocol) +
            32'(r.new_src_ip[31:16]) + 32'(r.new_src_ip[15:0]) +
            32'(r.new_dst_ip[31:16]) + 32'(r.new_dst_ip[15:0]);
      while (acc >> 16) acc = (acc & 32'hFFFF) + (acc >> 16);
      r.new_checksum = ~acc[15:0];
    end
    return r;
  endfunction

  function automatic prr_pkg::hdr_t base_hdr(logic [15:0] flen, logic [15:0] etype,
                                             logic [15:0] vit, logic [15:0] ttlp,
                                             logic [31:0] sip);
    prr_pkg::hdr_t h;
    h.frame_length    = flen;
    h.dest_mac        = prr_pkg::BALANCER_MAC_RST;
    h.source_mac      = 48'h0200_0000_0001;
    h.ether_type      = etype;
    h.version_ihl_tos = vit;
    h.total_len       = 16'h0028;
    h.ident           = '0;
    h.flags_fragment  = '0;
    h.ttl_protocol    = ttlp;
    h.src_ip          = sip;
    h.dst_ip          = prr_pkg::BALANCER_IP_RST;
    return h;
  endfunction

  // A frame that fails a test comes back with its addresses echoed.
  function automatic prr_pkg::res_t echo_res(prr_pkg::hdr_t h);
    prr_pkg::res_t r;
    r.verdict        = 1'b0;
    r.new_dest_mac   = h.dest_mac;
    r.new_source_mac = h.source_mac;
    r.new_src_ip     = h.src_ip;
    r.new_dst_ip     = h.dst_ip;
    r.new_checksum   = '0;
    return r;
  endfunction

  function automatic void add_row(prr_pkg::hdr_t h, bit typed, prr_pkg::res_t r);
    stim_row_t row;
    row.h     = h;
    row.typed = typed;
    row.r     = r;
    dir_rows.push_back(row);
  endfunction

  function automatic prr_pkg::hdr_t rand_hdr();
    prr_pkg::hdr_t h;
    int unsigned   kind;
    int unsigned   ihl;
    int unsigned   need;
    kind              = $urandom_range(99);
    h.frame_length    = 16'($urandom);
    h.dest_mac        = 48'({$urandom, $urandom});
    h.source_mac      = 48'({$urandom, $urandom});
    h.ether_type      = 16'($urandom);
    h.version_ihl_tos = 16'($urandom);
    h.total_len       = 16'($urandom);
    h.ident           = 16'($urandom);
    h.flags_fragment  = 16'($urandom);
    h.ttl_protocol    = 16'($urandom);
    h.src_ip          = $urandom;
    h.dst_ip          = $urandom;
    if ($urandom_range(1)) h.src_ip = lb_cfg.clnt_ip;
    if (kind < 75) begin
      ihl                     = $urandom_range(15, 5);
      need                    = 14 + 4 * ihl;
      h.ether_type            = prr_pkg::ETYPE_IPV4;
      h.version_ihl_tos[11:8] = 4'(ihl);
      h.ttl_protocol[7:0]     = prr_pkg::PROTO_TCP;
      if ($urandom_range(3) == 0) h.frame_length = 16'(need + $urandom_range(3));
      else h.frame_length = 16'($urandom_range(65535, need));
      // Some well-formed headers are made to fail a test.
      if (kind >= 60) begin
        case ($urandom_range(4))
          0: h.ether_type ^= 16'($urandom_range(65535, 1));
          1: h.ttl_protocol[7:0] ^= 8'($urandom_range(255, 1));
          2: h.version_ihl_tos[11:8] = 4'($urandom_range(4));
          3: h.frame_length = 16'($urandom_range(33));
          default: h.frame_length = 16'($urandom_range(need - 1));
        endcase
      end
    end
    return h;
  endfunction

  function automatic prr_pkg::cfg_t rand_cfg();
    prr_pkg::cfg_t c;
    c.clnt_ip      = $urandom;
    c.clnt_mac     = 48'({$urandom, $urandom});
    c.balancer_ip  = $urandom;
    c.balancer_mac = 48'({$urandom, $urandom});
    c.backend0_ip  = $urandom;
    c.backend0_mac = 48'({$urandom, $urandom});
    c.backend1_ip  = $urandom;
    c.backend1_mac = 48'({$urandom, $urandom});
    return c;
  endfunction

  // Called just after a rising edge; the write lands on the next one.
  task automatic write_reg(prr_pkg::cfg_idx_e idx, logic [prr_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      prr_pkg::CFG_CLNT_IP:      lb_cfg.clnt_ip      = val[prr_pkg::IpW-1:0];
      prr_pkg::CFG_CLNT_MAC:     lb_cfg.clnt_mac     = val;
      prr_pkg::CFG_BALANCER_IP:  lb_cfg.balancer_ip  = val[prr_pkg::IpW-1:0];
      prr_pkg::CFG_BALANCER_MAC: lb_cfg.balancer_mac = val;
      prr_pkg::CFG_BACKEND0_IP:  lb_cfg.backend0_ip  = val[prr_pkg::IpW-1:0];
      prr_pkg::CFG_BACKEND0_MAC: lb_cfg.backend0_mac = val;
      prr_pkg::CFG_BACKEND1_IP:  lb_cfg.backend1_ip  = val[prr_pkg::IpW-1:0];
      prr_pkg::CFG_BACKEND1_MAC: lb_cfg.backend1_mac = val;
      default: ;
    endcase
  endtask

  // The upper bits of the IP registers carry junk that must be dropped.
  task automatic program_regs(prr_pkg::cfg_t c);
    write_reg(prr_pkg::CFG_CLNT_IP,      {16'($urandom), c.clnt_ip});
    write_reg(prr_pkg::CFG_CLNT_MAC,     c.clnt_mac);
    write_reg(prr_pkg::CFG_BALANCER_IP,  {16'($urandom), c.balancer_ip});
    write_reg(prr_pkg::CFG_BALANCER_MAC, c.balancer_mac);
    write_reg(prr_pkg::CFG_BACKEND0_IP,  {16'($urandom), c.backend0_ip});
    write_reg(prr_pkg::CFG_BACKEND0_MAC, c.backend0_mac);
    write_reg(prr_pkg::CFG_BACKEND1_IP,  {16'($urandom), c.backend1_ip});
    write_reg(prr_pkg::CFG_BACKEND1_MAC, c.backend1_mac);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_hdr(prr_pkg::hdr_t h, bit typed, prr_pkg::res_t typed_res);
    int unsigned   gap;
    int unsigned   roll;
    prr_pkg::res_t pred;
    gap = 0;
    if (tx_gaps_on) begin
      roll = $urandom_range(99);
      if (roll < 60) gap = 0;
      else if (roll < 90) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 10);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h.dst_ip, h.src_ip, h.ttl_protocol, h.flags_fragment, h.ident,
                      h.total_len, h.version_ihl_tos, h.ether_type, h.source_mac,
                      h.dest_mac, h.frame_length};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = rewrite_header(h);
    pending_rewrites.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_rewrites.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    prr_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rewrites.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h/%h", $time,
                 m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_rewrites.pop_front();
        cmp_field("verdict", 64'(want.verdict), 64'(m_axis_tuser[0]));
        cmp_field("new_dest_mac", 64'(want.new_dest_mac), 64'(m_axis_tdata[47:0]));
        cmp_field("new_source_mac", 64'(want.new_source_mac), 64'(m_axis_tdata[95:48]));
        cmp_field("new_src_ip", 64'(want.new_src_ip), 64'(m_axis_tdata[127:96]));
        cmp_field("new_dst_ip", 64'(want.new_dst_ip), 64'(m_axis_tdata[159:128]));
        cmp_field("new_checksum", 64'(want.new_checksum), 64'(m_axis_tdata[175:160]));
      end
    end
  end

  // Result side: random stalls, and one long hold-off on request.
  initial begin : result_sink
    int          stall_left;
    int unsigned roll;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        roll = $urandom_range(99);
        if (!rx_relaxed || roll < 70) begin
          m_axis_tready <= 1'b1;
        end else if (roll < 93) begin
          m_axis_tready <= 1'b0;
          stall_left = $urandom_range(2);
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = $urandom_range(30, 8);
        end
      end
    end
  end

  initial begin : run_limit
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    prr_pkg::res_t rst_rewrite;
    prr_pkg::hdr_t h;
    prr_pkg::cfg_t c;
    lb_cfg.clnt_ip      = prr_pkg::CLNT_IP_RST;
    lb_cfg.clnt_mac     = prr_pkg::CLNT_MAC_RST;
    lb_cfg.balancer_ip  = prr_pkg::BALANCER_IP_RST;
    lb_cfg.balancer_mac = prr_pkg::BALANCER_MAC_RST;
    lb_cfg.backend0_ip  = '0;
    lb_cfg.backend0_mac = '0;
    lb_cfg.backend1_ip  = '0;
    lb_cfg.backend1_mac = '0;
    rr_next             = 1'b0;

    // Client frames straight after reset go to the zeroed backends in turn.
    rst_rewrite.verdict        = 1'b1;
    rst_rewrite.new_dest_mac   = '0;
    rst_rewrite.new_source_mac = prr_pkg::BALANCER_MAC_RST;
    rst_rewrite.new_src_ip     = prr_pkg::BALANCER_IP_RST;
    rst_rewrite.new_dst_ip     = '0;
    rst_rewrite.new_checksum   = 16'h70C7;
    h = base_hdr(16'd54, prr_pkg::ETYPE_IPV4, 16'h4500, 16'h4006, prr_pkg::CLNT_IP_RST);
    add_row(h, 1'b1, rst_rewrite);
    add_row(h, 1'b1, rst_rewrite);
    h = base_hdr(16'd0, prr_pkg::ETYPE_IPV4, 16'h4500, 16'h4006, prr_pkg::CLNT_IP_RST);
    add_row(h, 1'b1, echo_res(h));
    h.frame_length = 16'd13;
    add_row(h, 1'b1, echo_res(h));
    h.frame_length = 16'd14;
    add_row(h, 1'b1, echo_res(h));
    h.frame_length = 16'd33;
    add_row(h, 1'b1, echo_res(h));
    h = base_hdr(16'd60, 16'h86DD, 16'h4500, 16'h4006, prr_pkg::CLNT_IP_RST);
    add_row(h, 1'b1, echo_res(h));
    h = base_hdr(16'd60, prr_pkg::ETYPE_IPV4, 16'h4500, 16'h4011, prr_pkg::CLNT_IP_RST);
    add_row(h, 1'b1, echo_res(h));
    h = base_hdr(16'd60, prr_pkg::ETYPE_IPV4, 16'h4400, 16'h4006, prr_pkg::CLNT_IP_RST);
    add_row(h, 1'b1, echo_res(h));
    h = base_hdr(16'd60, prr_pkg::ETYPE_IPV4, 16'h4000, 16'h4006, prr_pkg::CLNT_IP_RST);
    add_row(h, 1'b1, echo_res(h));
    // Fifteen-word header one byte past the frame, then just fitting.
    h = base_hdr(16'd73, prr_pkg::ETYPE_IPV4, 16'h4F00, 16'h4006, 32'hC0A8_0001);
    add_row(h, 1'b1, echo_res(h));
    h.frame_length = 16'd74;
    add_row(h, 1'b0, rst_rewrite);
    h = base_hdr(16'd34, prr_pkg::ETYPE_IPV4, 16'h4500, 16'h4006, 32'hC0A8_0001);
    add_row(h, 1'b0, rst_rewrite);
    h = '1;
    add_row(h, 1'b1, echo_res(h));
    h = '0;
    add_row(h, 1'b1, echo_res(h));
    // The version nibble is not checked.
    h = base_hdr(16'd54, prr_pkg::ETYPE_IPV4, 16'hF5FF, 16'hFF06, prr_pkg::CLNT_IP_RST);
    add_row(h, 1'b0, rst_rewrite);
    h = base_hdr(16'hFFFF, prr_pkg::ETYPE_IPV4, 16'h05FF, 16'hFF06, 32'hFFFF_FFFF);
    h.total_len      = 16'hFFFF;
    h.ident          = 16'hFFFF;
    h.flags_fragment = 16'hFFFF;
    add_row(h, 1'b0, rst_rewrite);
    h.src_ip = prr_pkg::CLNT_IP_RST;
    add_row(h, 1'b0, rst_rewrite);
    add_row(h, 1'b0, rst_rewrite);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_hdr(dir_rows[i].h, dir_rows[i].typed, dir_rows[i].r);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: c = '0;
        1: c = '1;
        default: c = rand_cfg();
      endcase
      program_regs(c);
      tx_gaps_on = (p % 3 != 1);
      rx_relaxed = (p % 4 != 3);
      if (p == 4) begin
        // Keep offering transfers while the result side holds off.
        tx_gaps_on = 1'b0;
        hold_req   = 1'b1;
      end
      repeat (150) send_hdr(rand_hdr(), 1'b0, rst_rewrite);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
